// ===== rtl/pln_pkg.sv =====
// Shared types and constants for the periodic lattice neighbor index block.
`default_nettype none
package pln_pkg;

  localparam int SIDE_W  = 11;
  localparam int COORD_W = 10;
  localparam int DIMS_W  = 3;
  localparam int CFG_IDX_W = 1;

  typedef logic [SIDE_W-1:0]    side_t;
  typedef logic [COORD_W-1:0]   digit_t;
  typedef logic [DIMS_W-1:0]    dims_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SIDE_LENGTH = 1'd0;
  localparam cfg_idx_t CFG_DIMENSIONS  = 1'd1;

  localparam side_t SIDE_MIN   = 11'd2;
  localparam side_t SIDE_MAX   = 11'd1024;
  localparam side_t SIDE_RESET = 11'd2;
  localparam dims_t DIMS_RESET = 3'd2;

endpackage
`default_nettype wire

// ===== rtl/pln_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, remainder below the divisor.
`default_nettype none
module pln_div #(
  parameter int INDEX_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire logic [INDEX_BITS-1:0] dividend,
  input  wire pln_pkg::side_t        divisor,
  output logic [INDEX_BITS-1:0]      quotient,
  output pln_pkg::digit_t            remainder,
  output logic                       done
);
  import pln_pkg::*;

  localparam int CW = $clog2(INDEX_BITS + 1);

  logic [CW-1:0]         cnt_r;
  logic [INDEX_BITS-1:0] q_r;
  digit_t                rem_r;
  side_t                 shifted;
  logic                  ge;
  side_t                 diff;

  assign shifted = {rem_r, q_r[INDEX_BITS-1]};
  assign ge      = (shifted >= divisor);
  assign diff    = shifted - divisor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CW'(INDEX_BITS);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[INDEX_BITS-2:0], ge};
      // The remainder stays below the divisor, so it always fits the digit width.
      rem_r <= ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;
  assign done      = (cnt_r == '0);

endmodule
`default_nettype wire

// ===== rtl/periodic_lattice_neighbor_index_core.sv =====
// Top level: sequencer, power multiplier, digit store and result register of the lattice block.
// A vertex index is taken when start is high and busy is low. The block then computes the
// powers L^k with one multiplier step per dimension, checks the index against L^D, extracts
// the D base-L digits on a shared bit-serial divider and sends D result words on consecutive
// cycles. An out-of-range index ends after the check with a single flagged word. Each result
// word is shown for exactly one cycle with out_valid; the receiver cannot stall it and must
// take it then. The last word of a vertex appears in the same cycle in which busy falls, when
// the next start may already be taken. The user must write configuration only while busy is
// low and no word is still pending; the block itself does not enforce this.
`default_nettype none
module periodic_lattice_neighbor_index_core #(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 20,
  parameter int KW         = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire pln_pkg::cfg_idx_t     cfg_index,
  input  wire pln_pkg::side_t        cfg_wdata,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [INDEX_BITS-1:0] in_vertex_index,
  output logic                       out_valid,
  output logic [KW-1:0]              out_step_number,
  output pln_pkg::digit_t            out_coordinate_digit,
  output logic [INDEX_BITS-1:0]      out_neighbor_plus,
  output logic [INDEX_BITS-1:0]      out_neighbor_minus,
  output logic                       out_last_step,
  output logic                       out_index_out_of_range
);
  import pln_pkg::*;

  localparam int PW = INDEX_BITS + SIDE_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POW   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // Configuration registers.
  side_t side_r;
  dims_t dims_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      dims_r <= DIMS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIDE_LENGTH: side_r <= cfg_wdata;
        CFG_DIMENSIONS:  dims_r <= cfg_wdata[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective side and dimension count, taken at start.
  side_t                side_eff;
  logic [DIMS_W:0]      dims_ext;
  logic [DIMS_W:0]      dims_eff;
  logic [KW-1:0]        dlast_eff;

  always_comb begin
    if (side_r < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if (side_r > SIDE_MAX) begin
      side_eff = SIDE_MAX;
    end else begin
      side_eff = side_r;
    end
    dims_ext = {1'b0, dims_r};
    if (dims_r == '0) begin
      dims_eff = (DIMS_W+1)'(1);
    end else if (dims_ext > (DIMS_W+1)'(MAX_DIMS)) begin
      dims_eff = (DIMS_W+1)'(MAX_DIMS);
    end else begin
      dims_eff = dims_ext;
    end
    dlast_eff = KW'(dims_eff - 1'b1);
  end

  // Control and datapath registers.
  logic [2:0]            state_r, state_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [KW-1:0]         dlast_r;
  side_t                 l_r;
  logic [INDEX_BITS-1:0] v_r;
  logic [INDEX_BITS-1:0] p_r;
  logic                  ovf_r;
  logic [INDEX_BITS-1:0] pw_r   [MAX_DIMS];
  logic [INDEX_BITS-1:0] span_r [MAX_DIMS];
  digit_t                digit_r [MAX_DIMS];
  logic [MAX_DIMS-1:0]   is_max_r;
  logic [MAX_DIMS-1:0]   is_zero_r;

  logic                  accept;
  logic                  at_last;
  logic                  oor;
  logic [PW-1:0]         prod;

  logic                  div_load;
  logic [INDEX_BITS-1:0] div_dividend;
  logic [INDEX_BITS-1:0] div_quot;
  digit_t                div_rem;
  logic                  div_done;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign at_last = (k_r == dlast_r);
  // Without overflow p_r holds L^D exactly; with overflow every index fits.
  assign oor     = !ovf_r && (v_r >= p_r);
  assign prod    = PW'(p_r) * PW'(l_r);

  assign div_load     = (state_r == S_DLOAD);
  assign div_dividend = (k_r == '0) ? v_r : div_quot;

  pln_div #(
    .INDEX_BITS(INDEX_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dividend),
    .divisor  (l_r),
    .quotient (div_quot),
    .remainder(div_rem),
    .done     (div_done)
  );

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_POW;
          k_nxt     = '0;
        end
      end
      S_POW: begin
        if (at_last) begin
          state_nxt = S_CHECK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_CHECK: begin
        k_nxt     = '0;
        state_nxt = oor ? S_IDLE : S_DLOAD;
      end
      S_DLOAD: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          if (at_last) begin
            state_nxt = S_EMIT;
            k_nxt     = '0;
          end else begin
            state_nxt = S_DLOAD;
            k_nxt     = k_r + 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (at_last) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      k_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      k_r       <= k_nxt;
      out_valid <= ((state_r == S_CHECK) && oor) || (state_r == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r     <= in_vertex_index;
      l_r     <= side_eff;
      dlast_r <= dlast_eff;
      p_r     <= INDEX_BITS'(1);
      ovf_r   <= 1'b0;
    end
    if (state_r == S_POW) begin
      // L^(k+1) - L^k is (L-1)*L^k, the span of one full wrap along digit k.
      pw_r[k_r]   <= p_r;
      span_r[k_r] <= prod[INDEX_BITS-1:0] - p_r;
      p_r         <= prod[INDEX_BITS-1:0];
      ovf_r       <= ovf_r | (|prod[PW-1:INDEX_BITS]);
    end
    if ((state_r == S_DWAIT) && div_done) begin
      digit_r[k_r]   <= div_rem;
      is_max_r[k_r]  <= ({1'b0, div_rem} == (l_r - 1'b1));
      is_zero_r[k_r] <= (div_rem == '0);
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      out_step_number        <= '0;
      out_coordinate_digit   <= '0;
      out_neighbor_plus      <= '0;
      out_neighbor_minus     <= '0;
      out_last_step          <= 1'b1;
      out_index_out_of_range <= 1'b1;
    end else if (state_r == S_EMIT) begin
      out_step_number        <= k_r;
      out_coordinate_digit   <= digit_r[dlast_r - k_r];
      out_neighbor_plus      <= is_max_r[k_r] ? (v_r - span_r[k_r]) : (v_r + pw_r[k_r]);
      out_neighbor_minus     <= is_zero_r[k_r] ? (v_r + span_r[k_r]) : (v_r - pw_r[k_r]);
      out_last_step          <= at_last;
      out_index_out_of_range <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pln_checker.sv =====
// Port-level checks on the lattice block and their binding to the top level.
`default_nettype none
module pln_checker #(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 20,
  parameter int KW         = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  out_valid,
  input wire logic [KW-1:0]         out_step_number,
  input wire pln_pkg::digit_t       out_coordinate_digit,
  input wire logic                  out_last_step,
  input wire logic                  out_index_out_of_range
);
  import pln_pkg::*;

  // An accepted word always keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // Results only come out while working or right after the last step.
  a_valid_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy || $past(busy)))
    else $error("result word outside of a vertex computation");

  // The final word of a vertex is shown only once the block is free again.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_step) |-> !busy)
    else $error("busy still high with the last result word");

  // The words of one vertex follow each other without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_step) |=> out_valid)
    else $error("gap between result words of one vertex");

  // A flagged index gives one empty final word.
  a_oor_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_out_of_range) |->
      (out_last_step && (out_step_number == '0) && (out_coordinate_digit == '0)))
    else $error("malformed out-of-range word");

endmodule

bind periodic_lattice_neighbor_index_core pln_checker #(
  .MAX_DIMS  (MAX_DIMS),
  .INDEX_BITS(INDEX_BITS),
  .KW        (KW)
) u_pln_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_step_number       (out_step_number),
  .out_coordinate_digit  (out_coordinate_digit),
  .out_last_step         (out_last_step),
  .out_index_out_of_range(out_index_out_of_range)
);
`default_nettype wire

// ===== test/tb_periodic_lattice_neighbor_index_core.sv =====
// Testbench for the periodic lattice neighbor index core: directed table, random words, predictor.
module tb_periodic_lattice_neighbor_index_core;
  import pln_pkg::*;

  localparam int MAX_DIMS      = 4;
  localparam int INDEX_BITS    = 20;
  localparam longint unsigned INDEX_SPAN = 64'd1 << INDEX_BITS;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 120;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 40;

  typedef struct packed {
    logic [1:0]            step_no;
    digit_t                coord;
    logic [INDEX_BITS-1:0] nbr_up;
    logic [INDEX_BITS-1:0] nbr_dn;
    logic                  last_flag;
    logic                  oor_flag;
  } nbr_word_t;

  typedef struct packed {
    side_t                 side;
    dims_t                 dims;
    logic [INDEX_BITS-1:0] vertex;
    logic [2:0]            n_typed;
    nbr_word_t [3:0]       typed;
  } lattice_row_t;

  localparam nbr_word_t NO_WORD  = '0;
  localparam nbr_word_t OOR_WORD = '{2'd0, 10'd0, 20'd0, 20'd0, 1'b1, 1'b1};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = CFG_SIDE_LENGTH;
  side_t                 cfg_wdata = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [INDEX_BITS-1:0] in_vertex_index = '0;
  logic                  out_valid;
  logic [1:0]            out_step_number;
  digit_t                out_coordinate_digit;
  logic [INDEX_BITS-1:0] out_neighbor_plus;
  logic [INDEX_BITS-1:0] out_neighbor_minus;
  logic                  out_last_step;
  logic                  out_index_out_of_range;

  side_t        cur_side = SIDE_RESET;
  dims_t        cur_dims = DIMS_RESET;
  nbr_word_t    pending_words[$];
  lattice_row_t lattice_rows[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int unsigned  idle_pct = 0;
  nbr_word_t    got_word;
  nbr_word_t    exp_word;

  periodic_lattice_neighbor_index_core #(
    .MAX_DIMS(MAX_DIMS),
    .INDEX_BITS(INDEX_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .start(start),
    .busy(busy),
    .in_vertex_index(in_vertex_index),
    .out_valid(out_valid),
    .out_step_number(out_step_number),
    .out_coordinate_digit(out_coordinate_digit),
    .out_neighbor_plus(out_neighbor_plus),
    .out_neighbor_minus(out_neighbor_minus),
    .out_last_step(out_last_step),
    .out_index_out_of_range(out_index_out_of_range)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_periodic_lattice_neighbor_index_core: errors");
      $finish;
    end
  end

  function automatic longint unsigned eff_side();
    if (cur_side < SIDE_MIN) return SIDE_MIN;
    if (cur_side > SIDE_MAX) return SIDE_MAX;
    return cur_side;
  endfunction

  function automatic int unsigned eff_dims();
    if (cur_dims < 1) return 1;
    if (cur_dims > MAX_DIMS) return MAX_DIMS;
    return cur_dims;
  endfunction

  // L^D, saturated at the index space: anything that large admits every index.
  function automatic longint unsigned lattice_size();
    longint unsigned total;
    total = 1;
    for (int k = 0; k < eff_dims(); k++) begin
      if (total < INDEX_SPAN) total = total * eff_side();
      if (total > INDEX_SPAN) total = INDEX_SPAN;
    end
    return total;
  endfunction

  function automatic void predict_neighbors(input logic [INDEX_BITS-1:0] v);
    longint unsigned side, total, rest, p, span, up, dn;
    longint unsigned digit[MAX_DIMS];
    longint unsigned pw[MAX_DIMS];
    int unsigned     dims;
    nbr_word_t       w;
    side  = eff_side();
    dims  = eff_dims();
    total = lattice_size();
    if (v >= total && total < INDEX_SPAN) begin
      pending_words.insert(pending_words.size(), OOR_WORD);
      return;
    end
    rest = v;
    p = 1;
    for (int k = 0; k < dims; k++) begin
      digit[k] = rest % side;
      rest = rest / side;
      pw[k] = p;
      p = p * side;
    end
    for (int k = 0; k < dims; k++) begin
      span = (side - 1) * pw[k];
      up = (digit[k] == side - 1) ? v - span : v + pw[k];
      dn = (digit[k] == 0) ? v + span : v - pw[k];
      w.step_no   = 2'(k);
      w.coord     = digit_t'(digit[dims-1-k]);
      w.nbr_up    = INDEX_BITS'(up);
      w.nbr_dn    = INDEX_BITS'(dn);
      w.last_flag = (k == dims - 1);
      w.oor_flag  = 1'b0;
      pending_words.insert(pending_words.size(), w);
    end
  endfunction

  function automatic void check_field(input string fname, input longint unsigned expv,
                                      input longint unsigned gotv);
    if (expv != gotv) begin
      error_count++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, expv, gotv);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_word = '{out_step_number, out_coordinate_digit, out_neighbor_plus,
                   out_neighbor_minus, out_last_step, out_index_out_of_range};
      if (pending_words.size() == 0) begin
        error_count++;
        $display("%0t: word with none expected, got %h", $time, got_word);
      end else begin
        exp_word = pending_words.pop_front();
        check_field("step_number", exp_word.step_no, got_word.step_no);
        check_field("coordinate_digit", exp_word.coord, got_word.coord);
        check_field("neighbor_plus", exp_word.nbr_up, got_word.nbr_up);
        check_field("neighbor_minus", exp_word.nbr_dn, got_word.nbr_dn);
        check_field("last_step", exp_word.last_flag, got_word.last_flag);
        check_field("index_out_of_range", exp_word.oor_flag, got_word.oor_flag);
      end
    end
  end

  // Always advances at least one clock so start is never driven twice in one step.
  task automatic drain_words();
    if (start) start <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
  endtask

  task automatic write_lattice_config(input int unsigned side, input int unsigned dims);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SIDE_LENGTH;
    cfg_wdata <= side_t'(side);
    @(posedge clk);
    cur_side = side_t'(side);
    cfg_index <= CFG_DIMENSIONS;
    // Bits above the dimension field are junk that the block must ignore.
    cfg_wdata <= {8'($urandom_range(0, 255)), dims_t'(dims)};
    @(posedge clk);
    cur_dims = dims_t'(dims);
    cfg_we <= 1'b0;
  endtask

  task automatic reconfigure(input int unsigned side, input int unsigned dims);
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_lattice_config(side, dims);
  endtask

  // Leaves start high after the accepting edge; the next word decides whether it drops.
  task automatic send_vertex(input logic [INDEX_BITS-1:0] v, input int unsigned n_typed,
                             input nbr_word_t [3:0] typed);
    int unsigned gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && gap < 24) gap++;
    if (gap > 0 || !start) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
      if (gap == 0 && start == 1'b0 && !cfg_we) begin
        // start is already low and nothing is pending on it in this step
      end
    end
    start <= 1'b1;
    in_vertex_index <= v;
    do @(posedge clk); while (busy);
    if (n_typed == 0) predict_neighbors(v);
    else for (int i = 0; i < n_typed; i++) pending_words.insert(pending_words.size(), typed[i]);
  endtask

  task automatic add_row(input int unsigned side, input int unsigned dims,
                         input logic [INDEX_BITS-1:0] vertex, input int unsigned n_typed,
                         input nbr_word_t w0, input nbr_word_t w1);
    lattice_row_t r;
    r.side    = side_t'(side);
    r.dims    = dims_t'(dims);
    r.vertex  = vertex;
    r.n_typed = 3'(n_typed);
    r.typed   = {NO_WORD, NO_WORD, w1, w0};
    lattice_rows.insert(lattice_rows.size(), r);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_vertex();
    longint unsigned total;
    int unsigned     r;
    total = lattice_size();
    r = $urandom_range(0, 99);
    if (r < 70) return INDEX_BITS'($urandom_range(0, 32'(total - 1)));
    if (r < 85) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return INDEX_BITS'(total - 1);
        default: return INDEX_BITS'(total);
      endcase
    end
    return INDEX_BITS'($urandom);
  endfunction

  initial begin
    int unsigned phase_side[PHASES];
    int unsigned phase_dims[PHASES];
    int unsigned phase_idle[PHASES];
    int unsigned side, dims;
    phase_side = '{2, 1024, 3, 1023, 0, 0, 0, 0};
    phase_dims = '{1, 4, 4, 2, 0, 0, 0, 0};
    phase_idle = '{0, 58, 13, 0, 58, 13, 58, 0};

    // Reset setting is L=2, D=2: results read straight off the digit arithmetic.
    add_row(2, 2, 0, 2, '{2'd0, 10'd0, 20'd1, 20'd1, 1'b0, 1'b0},
                        '{2'd1, 10'd0, 20'd2, 20'd2, 1'b1, 1'b0});
    add_row(2, 2, 3, 2, '{2'd0, 10'd1, 20'd2, 20'd2, 1'b0, 1'b0},
                        '{2'd1, 10'd1, 20'd1, 20'd1, 1'b1, 1'b0});
    add_row(2, 2, 4, 1, OOR_WORD, NO_WORD);
    add_row(2, 2, 20'hFFFFF, 1, OOR_WORD, NO_WORD);
    add_row(0, 0, 1, 0, NO_WORD, NO_WORD);
    add_row(1, 0, 2, 1, OOR_WORD, NO_WORD);
    add_row(1024, 4, 0, 0, NO_WORD, NO_WORD);
    add_row(1024, 4, 20'hFFFFF, 0, NO_WORD, NO_WORD);
    add_row(1024, 4, 20'h5A5A5, 0, NO_WORD, NO_WORD);
    add_row(2047, 7, 20'hAAAAA, 0, NO_WORD, NO_WORD);
    add_row(1024, 1, 1023, 0, NO_WORD, NO_WORD);
    add_row(1024, 1, 1024, 1, OOR_WORD, NO_WORD);
    add_row(1024, 2, 20'hFFFFF, 0, NO_WORD, NO_WORD);
    add_row(1024, 3, 20'h80001, 0, NO_WORD, NO_WORD);
    add_row(1023, 2, 1046528, 0, NO_WORD, NO_WORD);
    add_row(1023, 2, 1046529, 1, OOR_WORD, NO_WORD);
    add_row(3, 4, 80, 0, NO_WORD, NO_WORD);
    add_row(3, 4, 81, 1, OOR_WORD, NO_WORD);
    add_row(3, 4, 40, 0, NO_WORD, NO_WORD);
    add_row(1000, 3, 20'h54321, 0, NO_WORD, NO_WORD);
    add_row(5, 5, 624, 0, NO_WORD, NO_WORD);
    add_row(5, 6, 625, 1, OOR_WORD, NO_WORD);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (lattice_rows[i]) begin
      if (lattice_rows[i].side != cur_side || lattice_rows[i].dims != cur_dims)
        reconfigure(lattice_rows[i].side, lattice_rows[i].dims);
      send_vertex(lattice_rows[i].vertex, lattice_rows[i].n_typed, lattice_rows[i].typed);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        side = phase_side[ph];
        dims = phase_dims[ph];
      end else begin
        side = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, 2047);
        dims = $urandom_range(0, 7);
      end
      reconfigure(side, dims);
      idle_pct = phase_idle[ph];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Now and then the sender holds off until the block has emptied out.
        if ($urandom_range(0, 29) == 0) drain_words();
        send_vertex(pick_vertex(), 0, '0);
      end
    end

    drain_words();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb_periodic_lattice_neighbor_index_core: clean");
    else $display("tb_periodic_lattice_neighbor_index_core: errors");
    $finish;
  end

endmodule
